// File: rtl/pscc_pkg.sv
// ----------------------------------------------------------------------------
// pscc_pkg
// Shared types and constants of the phase switch controller.
// ----------------------------------------------------------------------------
package pscc_pkg;

    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 3;
    localparam int VOLT_W  = 9;
    localparam int NUM_W   = 26;   // power * 1000 fits below 2^26
    localparam int DEN_W   = 11;   // 3 * 511 fits below 2^11

    localparam logic [CFG_W-1:0] RST_ON_THR   = 16'd4200;
    localparam logic [CFG_W-1:0] RST_OFF_THR  = 16'd4100;
    localparam logic [CFG_W-1:0] RST_ON_DIR   = 16'd6000;
    localparam logic [CFG_W-1:0] RST_OFF_DIR  = 16'd2000;
    localparam logic [CFG_W-1:0] RST_ON_DLY   = 16'd30;
    localparam logic [CFG_W-1:0] RST_OFF_DLY  = 16'd30;
    localparam logic [CFG_W-1:0] RST_COOLDOWN = 16'd300;
    localparam logic [CFG_W-1:0] RST_MIN_CUR  = 16'd6000;

    localparam logic [DEN_W-1:0] VOLT_SUM_MIN = 11'd600;
    localparam logic [15:0]      AMP_MIN_MA   = 16'd1000;
    localparam logic [NUM_W-1:0] MILLI        = 26'd1000;

    typedef enum logic [CIDX_W-1:0] {
        CFG_ON_THR   = 3'd0,
        CFG_OFF_THR  = 3'd1,
        CFG_ON_DIR   = 3'd2,
        CFG_OFF_DIR  = 3'd3,
        CFG_ON_DLY   = 3'd4,
        CFG_OFF_DLY  = 3'd5,
        CFG_COOLDOWN = 3'd6,
        CFG_MIN_CUR  = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_THREE  = 2'd1,
        CMD_SINGLE = 2'd2
    } t_switch_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COOL,
        S_ON,
        S_OFF,
        S_DIV,
        S_DONE
    } t_state;

endpackage

// File: rtl/pscc_div.sv
// ----------------------------------------------------------------------------
// pscc_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pscc_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pscc_pkg::NUM_W-1:0] i_num,
    input  logic [pscc_pkg::DEN_W-1:0] i_den,
    output logic                       o_done,
    output logic [pscc_pkg::NUM_W-1:0] o_quot
);
    import pscc_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   trial_pr;
    logic             q_bit;

    // partial remainder with the next numerator bit shifted in
    assign trial_pr = {r_rem, r_num[NUM_W-1]};
    assign q_bit    = (trial_pr >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(NUM_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], q_bit};
            if (q_bit) begin
                r_rem <= DEN_W'(trial_pr - {1'b0, r_den});
            end else begin
                r_rem <= trial_pr[DEN_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

// File: rtl/charger_phase_switch_controller.sv
// ----------------------------------------------------------------------------
// charger_phase_switch_controller
// Takes one item at a time: the input stalls until the result is loaded
// into the output register, and the 26-step serial divider sets the pace.
// The three dwell and cooldown timers share one subtractor, one per cycle.
// Reset (synchronous, active low) loads the default thresholds and clears
// all time stamps, the last phase and the last current.
// ----------------------------------------------------------------------------
module charger_phase_switch_controller #(
    parameter int TIME_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_now_s,
    input  logic [15:0] i_target_power_w,
    input  logic        i_charge_enable,
    input  logic        i_phase_reported,
    input  logic [8:0]  i_volt_l1,
    input  logic [8:0]  i_volt_l2,
    input  logic [8:0]  i_volt_l3,
    input  logic [15:0] i_amp_l1_ma,
    input  logic [15:0] i_amp_l2_ma,
    input  logic [15:0] i_amp_l3_ma,
    input  logic [15:0] i_hw_max_ma,
    input  logic [15:0] i_reported_user_ma,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_switch_cmd,
    output logic        o_current_valid,
    output logic [15:0] o_user_current_ma,
    output logic        o_send_current,
    output logic [15:0] o_cooldown_left_s,
    output logic [15:0] o_on_delay_left_s,
    output logic [15:0] o_off_delay_left_s
);
    import pscc_pkg::*;

    // ---- configuration registers ------------------------------------------
    logic [CFG_W-1:0] r_on_thr, r_off_thr, r_on_dir, r_off_dir;
    logic [CFG_W-1:0] r_on_dly, r_off_dly, r_cooldown, r_min_cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_thr   <= RST_ON_THR;
            r_off_thr  <= RST_OFF_THR;
            r_on_dir   <= RST_ON_DIR;
            r_off_dir  <= RST_OFF_DIR;
            r_on_dly   <= RST_ON_DLY;
            r_off_dly  <= RST_OFF_DLY;
            r_cooldown <= RST_COOLDOWN;
            r_min_cur  <= RST_MIN_CUR;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ON_THR:   r_on_thr   <= i_cfg_data;
                CFG_OFF_THR:  r_off_thr  <= i_cfg_data;
                CFG_ON_DIR:   r_on_dir   <= i_cfg_data;
                CFG_OFF_DIR:  r_off_dir  <= i_cfg_data;
                CFG_ON_DLY:   r_on_dly   <= i_cfg_data;
                CFG_OFF_DLY:  r_off_dly  <= i_cfg_data;
                CFG_COOLDOWN: r_cooldown <= i_cfg_data;
                CFG_MIN_CUR:  r_min_cur  <= i_cfg_data;
            endcase
        end
    end

    // ---- sequencer ----------------------------------------------------------
    t_state r_state, n_state;
    logic   in_take;
    logic   div_start;
    logic   out_load;
    logic   out_free;
    logic   div_done;

    // the output register frees up as soon as its transfer completes
    assign out_free = !o_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        in_take   = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    in_take = 1'b1;
                    n_state = S_COOL;
                end
            end
            S_COOL: begin
                // kick off the division while the timers are evaluated
                div_start = 1'b1;
                n_state   = S_ON;
            end
            S_ON:  n_state = S_OFF;
            S_OFF: n_state = S_DIV;
            S_DIV: begin
                if (div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold the finished result until the output register is free
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    // ---- captured item ------------------------------------------------------
    logic [TIME_WIDTH+31:0] now_wide;
    logic [TIME_WIDTH-1:0]  r_now;
    logic [15:0]            r_power, r_hw_max, r_reported;
    logic [15:0]            r_i1, r_i2, r_i3;
    logic [VOLT_W-1:0]      r_u1, r_u2, r_u3;
    logic                   r_en, r_phase;

    // time stamps wrap at TIME_WIDTH bits
    assign now_wide = {{TIME_WIDTH{1'b0}}, i_now_s};

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_now      <= now_wide[TIME_WIDTH-1:0];
            r_power    <= i_target_power_w;
            r_en       <= i_charge_enable;
            r_phase    <= i_phase_reported;
            r_u1       <= i_volt_l1;
            r_u2       <= i_volt_l2;
            r_u3       <= i_volt_l3;
            r_i1       <= i_amp_l1_ma;
            r_i2       <= i_amp_l2_ma;
            r_i3       <= i_amp_l3_ma;
            r_hw_max   <= i_hw_max_ma;
            r_reported <= i_reported_user_ma;
        end
    end

    // ---- controller state ---------------------------------------------------
    logic [TIME_WIDTH-1:0] r_switch_stamp, r_below_on_stamp, r_above_off_stamp;
    logic                  r_last_phase;
    logic [15:0]           r_last_current;
    logic [15:0]           r_cool_left, r_on_left, r_off_left;

    logic [TIME_WIDTH-1:0] sw_eff, on_eff, off_eff;

    // a change in the reported relay restarts the cooldown before anything else
    assign sw_eff  = (r_phase != r_last_phase) ? r_now : r_switch_stamp;
    // dwell stamps follow the clock while the condition is not met
    assign on_eff  = (!r_en || (r_power < r_on_thr))  ? r_now : r_below_on_stamp;
    assign off_eff = (!r_en || (r_power > r_off_thr)) ? r_now : r_above_off_stamp;

    // ---- shared timer unit --------------------------------------------------
    logic [TIME_WIDTH-1:0] t_stamp;
    logic [TIME_WIDTH-1:0] t_diff;
    logic [15:0]           t_base;
    logic [15:0]           t_left;
    logic                  t_over;

    always_comb begin
        unique case (r_state)
            S_COOL: begin
                t_stamp = sw_eff;
                t_base  = r_cooldown;
            end
            S_ON: begin
                t_stamp = on_eff;
                t_base  = r_on_dly;
            end
            S_OFF: begin
                t_stamp = off_eff;
                t_base  = r_off_dly;
            end
            default: begin
                t_stamp = r_now;
                t_base  = '0;
            end
        endcase
    end

    // elapsed time saturates at the base, what remains is base minus elapsed
    assign t_diff = r_now - t_stamp;
    assign t_over = ((t_diff >> 16) != '0) || (t_diff[15:0] > t_base);
    assign t_left = t_over ? 16'd0 : (t_base - t_diff[15:0]);

    // ---- divider --------------------------------------------------------------
    logic [DEN_W-1:0] volt_sum;
    logic             three_ph;
    logic [DEN_W-1:0] u1_ext;
    logic [DEN_W-1:0] div_den;
    logic [NUM_W-1:0] div_num;
    logic [NUM_W-1:0] div_quot;

    assign volt_sum = DEN_W'(r_u1) + DEN_W'(r_u2) + DEN_W'(r_u3);
    assign three_ph = r_phase && (volt_sum > VOLT_SUM_MIN) && (r_i1 > AMP_MIN_MA)
                      && (r_i2 > AMP_MIN_MA) && (r_i3 > AMP_MIN_MA);
    assign u1_ext   = DEN_W'(r_u1);
    assign div_den  = three_ph ? DEN_W'(u1_ext + {u1_ext[DEN_W-2:0], 1'b0}) : u1_ext;
    assign div_num  = NUM_W'(r_power) * MILLI;

    pscc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // ---- decision and clamp -------------------------------------------------
    logic        cool, go_on, go_off;
    t_switch_cmd cmd;
    logic [NUM_W-1:0] raw;
    logic [15:0] cur;
    logic        send;

    assign cool   = (r_cool_left == '0);
    assign go_on  = (r_power >= r_on_dir) || ((r_power >= r_on_thr) && (r_on_left == '0));
    assign go_off = (r_power <= r_off_dir) || ((r_power <= r_off_thr) && (r_off_left == '0));

    always_comb begin
        cmd = CMD_NONE;
        if (!r_en) begin
            // a stop while three-phase drops back to single-phase after cooldown
            if (r_phase && cool) begin
                cmd = CMD_SINGLE;
            end
        end else if (go_on) begin
            if (cool && !r_phase) begin
                cmd = CMD_THREE;
            end
        end else if (go_off) begin
            if (cool && r_phase) begin
                cmd = CMD_SINGLE;
            end
        end
    end

    // zero voltage on line one saturates to the hardware maximum; the maximum wins
    // over the minimum when they cross
    assign raw = (r_u1 == '0) ? NUM_W'(r_hw_max) : div_quot;

    always_comb begin
        priority if (raw >= NUM_W'(r_hw_max)) begin
            cur = r_hw_max;
        end else if (raw <= NUM_W'(r_min_cur)) begin
            cur = r_min_cur;
        end else begin
            cur = raw[15:0];
        end
    end

    assign send = (cur != r_last_current) || (r_reported != cur);

    // ---- state updates --------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_switch_stamp    <= '0;
            r_below_on_stamp  <= '0;
            r_above_off_stamp <= '0;
            r_last_phase      <= 1'b0;
            r_last_current    <= '0;
        end else begin
            if (r_state == S_COOL) begin
                r_switch_stamp <= sw_eff;
                r_last_phase   <= r_phase;
            end
            if (r_state == S_ON) begin
                r_below_on_stamp <= on_eff;
            end
            if (r_state == S_OFF) begin
                r_above_off_stamp <= off_eff;
            end
            if (out_load) begin
                if (cmd != CMD_NONE) begin
                    r_switch_stamp <= r_now;
                end
                if (r_en) begin
                    r_last_current <= cur;
                end
            end
        end
    end

    // timer results, one per step
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_COOL:  r_cool_left <= t_left;
            S_ON:    r_on_left   <= t_left;
            S_OFF:   r_off_left  <= t_left;
            default: ;
        endcase
    end

    // ---- output register ------------------------------------------------------
    logic        r_out_valid;
    logic [1:0]  r_out_cmd;
    logic        r_out_cur_valid;
    logic [15:0] r_out_cur;
    logic        r_out_send;
    logic [15:0] r_out_cool, r_out_on, r_out_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_cmd       <= cmd;
            r_out_cur_valid <= r_en;
            r_out_cur       <= r_en ? cur : 16'd0;
            r_out_send      <= r_en && send;
            // a switch just issued restarts the full cooldown
            r_out_cool      <= (cmd != CMD_NONE) ? r_cooldown : r_cool_left;
            r_out_on        <= r_on_left;
            r_out_off       <= r_off_left;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_switch_cmd       = r_out_cmd;
    assign o_current_valid    = r_out_cur_valid;
    assign o_user_current_ma  = r_out_cur;
    assign o_send_current     = r_out_send;
    assign o_cooldown_left_s  = r_out_cool;
    assign o_on_delay_left_s  = r_out_on;
    assign o_off_delay_left_s = r_out_off;

    // ---- assertions -------------------------------------------------------------
    a_done_needs_quot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> div_done)
        else $error("result stage reached before the divider finished");

    a_switch_restarts_cool : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_switch_cmd != CMD_NONE)) |-> (o_cooldown_left_s == r_cooldown))
        else $error("phase switch without a full cooldown");

    a_disabled_quiet : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_current_valid) |-> (!o_send_current && (o_user_current_ma == '0)))
        else $error("current reported while charging is disabled");

    a_result_from_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result transfer raised outside the result stage");

endmodule

// File: tb/charger_phase_switch_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// charger_phase_switch_controller_tb
// Drives control items through the phase switch controller and checks every
// decision field by field against an in-bench model of the hysteresis,
// dwell, cooldown and charge current rules. A directed opening covers the
// edge cases, then random traffic runs under several register settings,
// with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module charger_phase_switch_controller_tb;
    import pscc_pkg::*;

    typedef struct {
        logic [31:0] now_s;
        logic [15:0] power_w;
        logic        enable;
        logic        phase;
        logic [8:0]  volt_l1;
        logic [8:0]  volt_l2;
        logic [8:0]  volt_l3;
        logic [15:0] amp_l1;
        logic [15:0] amp_l2;
        logic [15:0] amp_l3;
        logic [15:0] hw_max;
        logic [15:0] reported_ma;
    } t_ctrl;

    typedef struct {
        logic [1:0]  cmd;
        logic        cur_valid;
        logic [15:0] cur_ma;
        logic        send;
        logic [15:0] cool_left;
        logic [15:0] on_left;
        logic [15:0] off_left;
    } t_result;

    typedef enum {PLAN_TYPICAL, PLAN_ZERO, PLAN_FULL, PLAN_WILD} t_reg_plan;
    typedef enum {RX_OPEN, RX_COIN, RX_COMB, RX_CHOKE} t_rx_mode;

    // Tracks the controller's registers and timers and holds the decisions
    // still owed by the block, oldest first.
    class t_phase_current_sb;
        logic [15:0] thr_on, thr_off, dir_on, dir_off;
        logic [15:0] dly_on, dly_off, cool_base, cur_floor;
        logic [31:0] sw_stamp, lo_stamp, hi_stamp;
        logic        prev_phase;
        logic [15:0] prev_current;
        logic [1:0]  last_cmd;
        t_result     owed[$];
        int          errors;

        function new();
            thr_on    = RST_ON_THR;
            thr_off   = RST_OFF_THR;
            dir_on    = RST_ON_DIR;
            dir_off   = RST_OFF_DIR;
            dly_on    = RST_ON_DLY;
            dly_off   = RST_OFF_DLY;
            cool_base = RST_COOLDOWN;
            cur_floor = RST_MIN_CUR;
            sw_stamp = '0;
            lo_stamp = '0;
            hi_stamp = '0;
            prev_phase = 1'b0;
            prev_current = '0;
            last_cmd = CMD_NONE;
            errors = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [15:0] v);
            case (idx)
                CFG_ON_THR:   thr_on = v;
                CFG_OFF_THR:  thr_off = v;
                CFG_ON_DIR:   dir_on = v;
                CFG_OFF_DIR:  dir_off = v;
                CFG_ON_DLY:   dly_on = v;
                CFG_OFF_DLY:  dly_off = v;
                CFG_COOLDOWN: cool_base = v;
                default:      cur_floor = v;
            endcase
        endfunction

        // Seconds remaining on a timer; the elapsed time wraps with the clock.
        function logic [15:0] secs_left(logic [31:0] now, logic [31:0] stamp,
                                        logic [15:0] base);
            logic [31:0] gone;
            gone = now - stamp;
            if (gone > {16'd0, base})
                gone = {16'd0, base};
            return base - gone[15:0];
        endfunction

        function t_result decide(t_ctrl c);
            t_result     r;
            logic        go_on, go_off, cool_ok, wide;
            logic [10:0] vsum, den;
            logic [25:0] num, raw;
            r.cmd = CMD_NONE;
            r.cur_valid = 1'b0;
            r.cur_ma = '0;
            r.send = 1'b0;

            // A change in the relay report restarts the cooldown first
            if (c.phase != prev_phase)
                sw_stamp = c.now_s;
            prev_phase = c.phase;

            // Disabled while three-phase: drop to single once cooled down
            if (!c.enable && c.phase && secs_left(c.now_s, sw_stamp, cool_base) == '0) begin
                r.cmd = CMD_SINGLE;
                sw_stamp = c.now_s;
            end

            if (c.enable) begin
                if (c.power_w < thr_on)
                    lo_stamp = c.now_s;
                if (c.power_w > thr_off)
                    hi_stamp = c.now_s;
                go_on = c.power_w >= dir_on ||
                        (c.power_w >= thr_on && secs_left(c.now_s, lo_stamp, dly_on) == '0);
                go_off = c.power_w <= dir_off ||
                         (c.power_w <= thr_off && secs_left(c.now_s, hi_stamp, dly_off) == '0);
                cool_ok = secs_left(c.now_s, sw_stamp, cool_base) == '0;
                if (go_on) begin
                    if (cool_ok && !c.phase) begin
                        r.cmd = CMD_THREE;
                        sw_stamp = c.now_s;
                    end
                end else if (go_off) begin
                    if (cool_ok && c.phase) begin
                        r.cmd = CMD_SINGLE;
                        sw_stamp = c.now_s;
                    end
                end

                vsum = 11'(c.volt_l1) + 11'(c.volt_l2) + 11'(c.volt_l3);
                wide = c.phase && vsum > VOLT_SUM_MIN && c.amp_l1 > AMP_MIN_MA &&
                       c.amp_l2 > AMP_MIN_MA && c.amp_l3 > AMP_MIN_MA;
                num = 26'(c.power_w) * MILLI;
                den = wide ? 11'(c.volt_l1) * 11'd3 : 11'(c.volt_l1);
                if (c.volt_l1 == '0)
                    raw = 26'(c.hw_max);
                else
                    raw = num / 26'(den);

                // Maximum wins over the floor when the two cross
                if (raw >= 26'(c.hw_max))
                    r.cur_ma = c.hw_max;
                else if (raw <= 26'(cur_floor))
                    r.cur_ma = cur_floor;
                else
                    r.cur_ma = raw[15:0];
                r.send = (r.cur_ma != prev_current) || (c.reported_ma != r.cur_ma);
                prev_current = r.cur_ma;
                r.cur_valid = 1'b1;
            end else begin
                lo_stamp = c.now_s;
                hi_stamp = c.now_s;
            end

            r.cool_left = secs_left(c.now_s, sw_stamp, cool_base);
            r.on_left   = secs_left(c.now_s, lo_stamp, dly_on);
            r.off_left  = secs_left(c.now_s, hi_stamp, dly_off);
            return r;
        endfunction

        function void note_transfer(t_ctrl c);
            t_result r;
            r = decide(c);
            last_cmd = r.cmd;
            owed.push_back(r);
        endfunction

        function void tally_field(string what, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0d, got %0d",
                         $time, what, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (owed.size() == 0) begin
                errors++;
                $display("%0t ns: result with none outstanding, expected nothing, got cmd %0d",
                         $time, got.cmd);
                return;
            end
            want = owed.pop_front();
            tally_field("switch_cmd",       16'(want.cmd),       16'(got.cmd));
            tally_field("current_valid",    16'(want.cur_valid), 16'(got.cur_valid));
            tally_field("user_current_ma",  want.cur_ma,         got.cur_ma);
            tally_field("send_current",     16'(want.send),      16'(got.send));
            tally_field("cooldown_left_s",  want.cool_left,      got.cool_left);
            tally_field("on_delay_left_s",  want.on_left,        got.on_left);
            tally_field("off_delay_left_s", want.off_left,       got.off_left);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = '0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] now_s = '0;
    logic [15:0] power_w = '0;
    logic        enable = 1'b0;
    logic        phase = 1'b0;
    logic [8:0]  volt_l1 = '0, volt_l2 = '0, volt_l3 = '0;
    logic [15:0] amp_l1 = '0, amp_l2 = '0, amp_l3 = '0;
    logic [15:0] hw_max = '0;
    logic [15:0] reported_ma = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  switch_cmd;
    logic        current_valid;
    logic [15:0] user_current_ma;
    logic        send_current;
    logic [15:0] cooldown_left_s, on_delay_left_s, off_delay_left_s;

    t_phase_current_sb sb;
    logic [15:0]       reg_plan [8];
    int                burst_left = 0;
    logic [31:0]       clock_s = '0;
    logic              relay = 1'b0;
    logic [15:0]       power_hold = 16'd4000;
    t_rx_mode          rx_mode = RX_OPEN;
    int                rx_span = 0;
    int                rx_tick = 0;
    t_result           seen;

    charger_phase_switch_controller dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_idx          (cfg_idx),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_now_s            (now_s),
        .i_target_power_w   (power_w),
        .i_charge_enable    (enable),
        .i_phase_reported   (phase),
        .i_volt_l1          (volt_l1),
        .i_volt_l2          (volt_l2),
        .i_volt_l3          (volt_l3),
        .i_amp_l1_ma        (amp_l1),
        .i_amp_l2_ma        (amp_l2),
        .i_amp_l3_ma        (amp_l3),
        .i_hw_max_ma        (hw_max),
        .i_reported_user_ma (reported_ma),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_switch_cmd       (switch_cmd),
        .o_current_valid    (current_valid),
        .o_user_current_ma  (user_current_ma),
        .o_send_current     (send_current),
        .o_cooldown_left_s  (cooldown_left_s),
        .o_on_delay_left_s  (on_delay_left_s),
        .o_off_delay_left_s (off_delay_left_s)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Collect results on the pre-edge handshake, then pick the next stall.
    // The receiver moves between open, coin-toss, comb and choked spells.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            seen.cmd       = switch_cmd;
            seen.cur_valid = current_valid;
            seen.cur_ma    = user_current_ma;
            seen.send      = send_current;
            seen.cool_left = cooldown_left_s;
            seen.on_left   = on_delay_left_s;
            seen.off_left  = off_delay_left_s;
            sb.check_result(seen);
        end
        if (rx_span == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_span = $urandom_range(16, 300);
        end else begin
            rx_span--;
        end
        rx_tick++;
        case (rx_mode)
            RX_OPEN:  out_stall <= 1'b0;
            RX_COIN:  out_stall <= ($urandom_range(0, 1) == 0);
            RX_COMB:  out_stall <= ((rx_tick % 9) < 4);
            default:  out_stall <= ($urandom_range(0, 9) < 8);
        endcase
    end

    // Hold the item until it is taken, note it, then either carry on with
    // the burst or drop valid for a random gap.
    task automatic push_ctrl(input t_ctrl c);
        in_valid    <= 1'b1;
        now_s       <= c.now_s;
        power_w     <= c.power_w;
        enable      <= c.enable;
        phase       <= c.phase;
        volt_l1     <= c.volt_l1;
        volt_l2     <= c.volt_l2;
        volt_l3     <= c.volt_l3;
        amp_l1      <= c.amp_l1;
        amp_l2      <= c.amp_l2;
        amp_l3      <= c.amp_l3;
        hw_max      <= c.hw_max;
        reported_ma <= c.reported_ma;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_transfer(c);
        if (burst_left == 0) begin
            burst_left = $urandom_range(0, 24);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 40))
                @(posedge clk);
        end else begin
            burst_left--;
        end
    endtask

    function automatic t_ctrl mk(int unsigned t, int p, bit en, bit ph,
                                 int u1, int u2, int u3, int a1, int a2, int a3,
                                 int hw, int rep);
        t_ctrl c;
        c.now_s = t;
        c.power_w = 16'(p);
        c.enable = en;
        c.phase = ph;
        c.volt_l1 = 9'(u1);
        c.volt_l2 = 9'(u2);
        c.volt_l3 = 9'(u3);
        c.amp_l1 = 16'(a1);
        c.amp_l2 = 16'(a2);
        c.amp_l3 = 16'(a3);
        c.hw_max = 16'(hw);
        c.reported_ma = 16'(rep);
        return c;
    endfunction

    function automatic logic [15:0] sat16(int v);
        return (v < 0) ? 16'd0 : (v > 65535) ? 16'hFFFF : 16'(v);
    endfunction

    function automatic logic [15:0] roll_amp();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            return 16'($urandom_range(995, 1005));
        if (pick == 2)
            return 16'($urandom);
        return 16'($urandom_range(1001, 16000));
    endfunction

    // Mostly a plausible session: time creeping forward, power lingering
    // near the thresholds, the relay obeying commands. The rest is noise.
    function automatic t_ctrl roll_ctrl();
        t_ctrl c;
        int    pick;
        int    centre;
        int    offs;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            c = mk($urandom, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom, $urandom);
            return c;
        end

        pick = $urandom_range(0, 99);
        if (pick < 85)
            clock_s += $urandom_range(0, 45);
        else if (pick < 93)
            clock_s += $urandom_range(46, 3000);
        else if (pick < 97)
            clock_s -= $urandom_range(1, 100);
        else
            clock_s += $urandom;

        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 4))
                0:       centre = int'(sb.thr_on);
                1:       centre = int'(sb.thr_off);
                2:       centre = int'(sb.dir_on);
                3:       centre = int'(sb.dir_off);
                default: centre = int'($urandom_range(0, 65535));
            endcase
            offs = ($urandom_range(0, 4) == 0) ? 0 : int'($urandom_range(0, 400)) - 200;
            power_hold = sat16(centre + offs);
        end

        // Follow the last command most of the time, occasionally misbehave
        if (sb.last_cmd == CMD_THREE && $urandom_range(0, 9) != 0)
            relay = 1'b1;
        else if (sb.last_cmd == CMD_SINGLE && $urandom_range(0, 9) != 0)
            relay = 1'b0;
        else if ($urandom_range(0, 39) == 0)
            relay = ~relay;

        c.now_s = clock_s;
        c.power_w = power_hold;
        c.enable = ($urandom_range(0, 9) != 0);
        c.phase = relay;

        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            c.volt_l1 = '0;
            c.volt_l2 = 9'($urandom_range(215, 245));
            c.volt_l3 = 9'($urandom_range(215, 245));
        end else if (pick == 1) begin
            c.volt_l1 = 9'($urandom_range(200, 201));
            c.volt_l2 = 9'd200;
            c.volt_l3 = 9'($urandom_range(199, 201));
        end else if (pick == 2) begin
            c.volt_l1 = 9'($urandom);
            c.volt_l2 = 9'($urandom);
            c.volt_l3 = 9'($urandom);
        end else begin
            c.volt_l1 = 9'($urandom_range(215, 245));
            c.volt_l2 = 9'($urandom_range(215, 245));
            c.volt_l3 = 9'($urandom_range(215, 245));
        end
        c.amp_l1 = roll_amp();
        c.amp_l2 = roll_amp();
        c.amp_l3 = roll_amp();

        pick = $urandom_range(0, 19);
        if (pick < 12)
            c.hw_max = 16'd16000;
        else if (pick < 15)
            c.hw_max = 16'd32000;
        else if (pick < 18)
            c.hw_max = 16'($urandom);
        else
            c.hw_max = 16'($urandom_range(0, 7000));

        c.reported_ma = ($urandom_range(0, 1) == 0) ? sb.prev_current : 16'($urandom);
        return c;
    endfunction

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++)
            push_ctrl(roll_ctrl());
    endtask

    // Drop valid, wait out every owed decision, then let the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.owed.size() != 0)
            @(posedge clk);
        repeat (40)
            @(posedge clk);
    endtask

    task automatic load_regs();
        t_cfg_idx idx;
        idx = idx.first();
        do begin
            cfg_we   <= 1'b1;
            cfg_idx  <= idx;
            cfg_data <= reg_plan[idx];
            @(posedge clk);
            sb.set_reg(idx, reg_plan[idx]);
            idx = idx.next();
        end while (idx != idx.first());
        cfg_we <= 1'b0;
    endtask

    task automatic reconfigure(input t_reg_plan plan);
        int on_thr;
        drain();
        case (plan)
            PLAN_ZERO: begin
                foreach (reg_plan[k])
                    reg_plan[k] = 16'd0;
            end
            PLAN_FULL: begin
                foreach (reg_plan[k])
                    reg_plan[k] = 16'hFFFF;
            end
            PLAN_WILD: begin
                foreach (reg_plan[k])
                    reg_plan[k] = 16'($urandom);
            end
            default: begin
                on_thr = $urandom_range(3000, 8000);
                reg_plan[CFG_ON_THR]   = 16'(on_thr);
                reg_plan[CFG_OFF_THR]  = 16'(on_thr - int'($urandom_range(0, 400)));
                reg_plan[CFG_ON_DIR]   = 16'(on_thr + int'($urandom_range(0, 3000)));
                reg_plan[CFG_OFF_DIR]  = 16'($urandom_range(500, 2500));
                reg_plan[CFG_ON_DLY]   = 16'($urandom_range(0, 60));
                reg_plan[CFG_OFF_DLY]  = 16'($urandom_range(0, 60));
                reg_plan[CFG_COOLDOWN] = 16'($urandom_range(0, 240));
                reg_plan[CFG_MIN_CUR]  = 16'($urandom_range(0, 8000));
            end
        endcase
        load_regs();
    endtask

    initial begin
        sb = new();
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening on the reset thresholds
        // Inside the first cooldown: no switch whatever the power
        push_ctrl(mk(0, 0, 1, 0, 230, 230, 230, 0, 0, 0, 16000, 0));
        push_ctrl(mk(10, 65535, 1, 0, 511, 511, 511, 16000, 16000, 16000, 16000, 16000));
        // Cooldown over, direct on threshold reached: three-phase
        push_ctrl(mk(300, 6000, 1, 0, 230, 230, 230, 8000, 8000, 8000, 16000, 6000));
        // Relay follows; the three-phase formula needs every line above 1000 mA
        push_ctrl(mk(301, 6000, 1, 1, 230, 230, 230, 1001, 1001, 1001, 16000, 0));
        push_ctrl(mk(302, 6000, 1, 1, 230, 230, 230, 1000, 1001, 1001, 16000, 0));
        // Voltage sum exactly at and just above the limit
        push_ctrl(mk(303, 6000, 1, 1, 200, 200, 200, 8000, 8000, 8000, 16000, 0));
        push_ctrl(mk(304, 6000, 1, 1, 201, 200, 200, 8000, 8000, 8000, 16000, 0));
        // Zero voltage on line one saturates to the maximum
        push_ctrl(mk(305, 6000, 1, 1, 0, 230, 230, 8000, 8000, 8000, 16000, 0));
        // Zero maximum, then a maximum below the floor
        push_ctrl(mk(306, 30000, 1, 1, 230, 230, 230, 8000, 8000, 8000, 0, 0));
        push_ctrl(mk(307, 30000, 1, 1, 230, 230, 230, 8000, 8000, 8000, 5000, 0));
        // Unchanged and already reported: nothing to send
        push_ctrl(mk(308, 30000, 1, 1, 230, 230, 230, 8000, 8000, 8000, 5000, 5000));
        // Largest quotient against the largest maximum
        push_ctrl(mk(309, 65535, 1, 1, 1, 1, 1, 65535, 65535, 65535, 65535, 0));
        // Hysteresis band, then below the off threshold through the dwell
        push_ctrl(mk(320, 4150, 1, 1, 230, 230, 230, 8000, 8000, 8000, 16000, 0));
        push_ctrl(mk(340, 4000, 1, 1, 230, 230, 230, 8000, 8000, 8000, 16000, 0));
        push_ctrl(mk(360, 4000, 1, 1, 230, 230, 230, 8000, 8000, 8000, 16000, 0));
        push_ctrl(mk(610, 4000, 1, 1, 230, 230, 230, 8000, 8000, 8000, 16000, 0));
        // Disabled while still three-phase: held by cooldown, then forced down
        push_ctrl(mk(611, 4000, 0, 1, 230, 230, 230, 8000, 8000, 8000, 16000, 0));
        push_ctrl(mk(920, 0, 0, 1, 230, 230, 230, 8000, 8000, 8000, 16000, 0));
        // Relay drops; power exactly on the direct off threshold
        push_ctrl(mk(921, 2000, 1, 0, 230, 230, 230, 8000, 8000, 8000, 16000, 6000));
        // Cooldown spanning the wrap of the seconds counter
        push_ctrl(mk(32'hFFFF_FFF0, 4300, 1, 0, 230, 230, 230, 8000, 8000, 8000, 16000, 0));
        push_ctrl(mk(32'h0000_0010, 4300, 1, 0, 230, 230, 230, 8000, 8000, 8000, 16000, 0));
        push_ctrl(mk(32'h0000_0011, 4200, 1, 1, 511, 511, 511, 8000, 8000, 8000, 16000, 0));
        clock_s = 32'h0000_0011;
        relay = 1'b1;

        run_random(200);
        reconfigure(PLAN_TYPICAL);
        run_random(200);
        reconfigure(PLAN_ZERO);
        run_random(60);
        reconfigure(PLAN_FULL);
        run_random(60);
        reconfigure(PLAN_WILD);
        run_random(80);
        reconfigure(PLAN_TYPICAL);
        run_random(100);

        in_valid <= 1'b0;
        while (sb.owed.size() != 0)
            @(posedge clk);
        repeat (60)
            @(posedge clk);
        if (sb.errors == 0)
            $display("** charger_phase_switch_controller: PASSED **");
        else
            $display("** charger_phase_switch_controller: FAILED **");
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("** charger_phase_switch_controller: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
rtl/pscc_pkg.sv
rtl/pscc_div.sv
rtl/charger_phase_switch_controller.sv
tb/charger_phase_switch_controller_tb.sv
